// ----- sv/cleb_pkg.sv -----
// Package for the console line edit buffer.
// Holds key codes, result kinds and the beat types of both channels.
// No dependencies.
package cleb_pkg;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_NL     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_T = 8'h14;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_ECHO   = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_DUMP   = 3'd3,
    KIND_SWITCH = 3'd4,
    KIND_RBYTE  = 3'd5,
    KIND_REOF   = 3'd6,
    KIND_REMPTY = 3'd7
  } kind_e;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] key_code;
    logic       read_in_progress;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    logic [7:0] erase_count;
    logic       line_ready;
  } out_t;

endpackage

// ----- sv/console_line_edit_buffer.sv -----
// Top level of the console line edit buffer: character ring, pointers and edit logic.
// Depends on cleb_pkg for key codes, result kinds and beat types.
//
// Canonical-mode keyboard line buffer. Each input beat carries either a key code
// or a request for one byte from a reader, and each one yields exactly one result
// beat. Keys are edited into a character ring (RING_DEPTH entries) behind an edit
// pointer; newline, ctrl-D or a full ring commits the line, backspace/DEL and
// ctrl-U erase uncommitted characters, ctrl-P and ctrl-T are flagged as requests.
// A read pops one committed byte; a ctrl-D met after earlier bytes of the same
// read stays in the ring. The block takes one beat every cycle while the output
// is not stalled: a beat is registered at accept together with the ring read at
// the pointer it will see, is decoded in the next cycle against the pointer
// registers, and its result lands in the output register when the output can
// take it. The ring is a single memory with one write port (key store) and one
// registered read port (reader pop), with a bypass for a byte written in the
// same cycle. A stalled output holds the whole chain; the input keeps taking
// beats while the decode stage is empty. The ring needs no clearing after
// reset.
module console_line_edit_buffer #(
  parameter int RING_DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cleb_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cleb_pkg::out_t out_data_o
);
  import cleb_pkg::*;

  // Pointers count modulo twice the depth so full and empty differ.
  localparam int PTR_W = $clog2(RING_DEPTH) + 1;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] DEPTH_P   = PTR_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * RING_DEPTH - 1);
  localparam logic [PTR_W:0]   PTR_MOD   = (PTR_W + 1)'(2 * RING_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_LAST) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? PTR_LAST : p - 1'b1;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + PTR_MOD - {1'b0, b};
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[IDX_W-1:0];
  endfunction

  // Character ring and its registered read port.
  logic [7:0] ring_q [RING_DEPTH];
  logic [7:0] rd_q;

  // Decode stage.
  logic s1_valid_q;
  in_t  s1_q;

  // Pointer state.
  logic [PTR_W-1:0] read_ptr_q, read_ptr_d;
  logic [PTR_W-1:0] commit_ptr_q, commit_ptr_d;
  logic [PTR_W-1:0] edit_ptr_q, edit_ptr_d;

  // Output register.
  logic out_valid_q;
  out_t out_q;
  out_t res;

  logic             adv;
  logic             fire;
  logic             in_accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       wr_char;
  logic [7:0]       key_char;

  // Advance the decode stage whenever the output register can take its result.
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Map carriage return to newline before storing and echoing.
  assign key_char = (s1_q.key_code == KEY_CR) ? KEY_NL : s1_q.key_code;
  assign wr_addr  = ptr_slot(edit_ptr_q);
  assign wr_char  = key_char;
  // Read at the pointer that the next beat will see after this one retires.
  assign rd_addr  = ptr_slot(read_ptr_d);

  always_comb begin
    read_ptr_d   = read_ptr_q;
    commit_ptr_d = commit_ptr_q;
    edit_ptr_d   = edit_ptr_q;
    wr_en        = 1'b0;
    res          = '0;
    res.kind     = KIND_NONE;
    if (fire) begin
      if (s1_q.command == CMD_READ) begin
        if (read_ptr_q == commit_ptr_q) begin
          res.kind = KIND_REMPTY;
        end else if (rd_q == KEY_CTRL_D) begin
          // Keep the ctrl-D for the next read if this read already has bytes.
          if (!s1_q.read_in_progress) begin
            read_ptr_d = ptr_inc(read_ptr_q);
          end
          res.kind = KIND_REOF;
        end else begin
          read_ptr_d   = ptr_inc(read_ptr_q);
          res.kind     = KIND_RBYTE;
          res.char_out = rd_q;
        end
      end else begin
        case (s1_q.key_code) inside
          KEY_CTRL_P: res.kind = KIND_DUMP;
          KEY_CTRL_T: res.kind = KIND_SWITCH;
          KEY_CTRL_U: begin
            res.kind        = KIND_ERASE;
            res.erase_count = 8'(ptr_diff(edit_ptr_q, commit_ptr_q));
            edit_ptr_d      = commit_ptr_q;
          end
          KEY_CTRL_H, KEY_DEL: begin
            res.kind = KIND_ERASE;
            if (edit_ptr_q != commit_ptr_q) begin
              edit_ptr_d      = ptr_dec(edit_ptr_q);
              res.erase_count = 8'd1;
            end
          end
          default: begin
            // Drop a null key or any key that meets a full ring.
            if (s1_q.key_code != KEY_NUL &&
                ptr_diff(edit_ptr_q, read_ptr_q) < DEPTH_P) begin
              wr_en        = 1'b1;
              edit_ptr_d   = ptr_inc(edit_ptr_q);
              res.kind     = KIND_ECHO;
              res.char_out = key_char;
              if (key_char == KEY_NL || key_char == KEY_CTRL_D ||
                  ptr_diff(edit_ptr_d, read_ptr_q) == DEPTH_P) begin
                commit_ptr_d   = edit_ptr_d;
                res.line_ready = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // Ring write from the key store.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[wr_addr] <= wr_char;
    end
  end

  // Ring read at accept; forward a byte written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= (wr_en && wr_addr == rd_addr) ? wr_char : ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      read_ptr_q   <= '0;
      commit_ptr_q <= '0;
      edit_ptr_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      read_ptr_q   <= read_ptr_d;
      commit_ptr_q <= commit_ptr_d;
      edit_ptr_q   <= edit_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  // Pointer order: read <= commit <= edit <= read + depth.
  a_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_diff(commit_ptr_q, read_ptr_q) <= ptr_diff(edit_ptr_q, read_ptr_q) &&
    ptr_diff(edit_ptr_q, read_ptr_q) <= DEPTH_P)
    else $error("ring pointers out of order");

  // Input is only held back by a full decode stage.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty decode stage");

  // Only a stored key can commit a line.
  a_ready_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_ready |-> out_data_o.kind == KIND_ECHO)
    else $error("line commit without echo");

  // Kill line leaves no uncommitted characters.
  a_kill_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.command == CMD_KEY && s1_q.key_code == KEY_CTRL_U
    |=> edit_ptr_q == commit_ptr_q)
    else $error("kill line left characters behind");

  // A retired beat always reaches the output register.
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result lost");

endmodule

// ----- tb/console_line_edit_buffer_tb.sv -----
// Testbench for the console line edit buffer: directed edit/read beats, ring-full,
// backpressure and random typing sessions, checked against an in-bench line model.
// Depends on cleb_pkg and console_line_edit_buffer.
module console_line_edit_buffer_tb;
  import cleb_pkg::*;

  localparam int RING_DEPTH = 128;
  localparam int MAX_GAP    = 14;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;

  // Line model state: character ring and the read/commit/edit pointers.
  // Pointers run modulo 2*RING_DEPTH, which is exactly their 8-bit width.
  logic [7:0] line_ring [RING_DEPTH];
  logic [7:0] rd_ptr;
  logic [7:0] cm_ptr;
  logic [7:0] ed_ptr;

  // Results predicted at input accept, oldest first.
  out_t pending_results[$];

  int mismatches;
  int beats_sent;       // beats that do something (key zero excluded)
  int send_gap_max;     // sender idle draw bound for the current test
  int recv_gap_max;     // receiver stall draw bound for the current test
  int long_hold_cycles; // one-shot long stall requested by a test

  console_line_edit_buffer #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every beat with the longest
  // sender gap and receiver stall, plus the long hold and pipeline latency).
  initial begin
    #600000;
    $display("console_line_edit_buffer: mismatch");
    $finish;
  end

  // Advance the line model by one beat and return the result it produces.
  function automatic out_t predict_line_edit(in_t b);
    out_t       r;
    logic [7:0] ch;
    logic [7:0] fill;
    r = '0;
    r.kind = KIND_NONE;
    if (b.command == CMD_READ) begin
      if (rd_ptr == cm_ptr) begin
        r.kind = KIND_REMPTY;
      end else begin
        ch = line_ring[int'(rd_ptr) % RING_DEPTH];
        if (ch == KEY_CTRL_D) begin
          // Keep the ctrl-D for the next read if this read already got bytes.
          r.kind = KIND_REOF;
          if (!b.read_in_progress) rd_ptr = rd_ptr + 8'd1;
        end else begin
          r.kind = KIND_RBYTE;
          r.char_out = ch;
          rd_ptr = rd_ptr + 8'd1;
        end
      end
    end else begin
      case (b.key_code)
        KEY_CTRL_P: r.kind = KIND_DUMP;
        KEY_CTRL_T: r.kind = KIND_SWITCH;
        KEY_CTRL_U: begin
          r.kind = KIND_ERASE;
          r.erase_count = ed_ptr - cm_ptr;
          ed_ptr = cm_ptr;
        end
        KEY_CTRL_H, KEY_DEL: begin
          r.kind = KIND_ERASE;
          if (ed_ptr != cm_ptr) begin
            ed_ptr = ed_ptr - 8'd1;
            r.erase_count = 8'd1;
          end
        end
        default: begin
          fill = ed_ptr - rd_ptr;
          if (b.key_code != KEY_NUL && int'(fill) < RING_DEPTH) begin
            ch = (b.key_code == KEY_CR) ? KEY_NL : b.key_code;
            line_ring[int'(ed_ptr) % RING_DEPTH] = ch;
            ed_ptr = ed_ptr + 8'd1;
            fill = ed_ptr - rd_ptr;
            r.kind = KIND_ECHO;
            r.char_out = ch;
            // Newline, ctrl-D or a ring that just filled up commits the line.
            if (ch == KEY_NL || ch == KEY_CTRL_D || int'(fill) == RING_DEPTH) begin
              cm_ptr = ed_ptr;
              r.line_ready = 1'b1;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  // Offer one beat after a random idle gap; hold it until accepted, then
  // record the predicted result. Valid is only lowered when a gap is drawn,
  // so back-to-back beats never see valid dropped and raised in one step.
  task automatic send_beat(cmd_e cmd, logic [7:0] key, logic rip);
    int  gap;
    in_t b;
    gap = $urandom_range(0, send_gap_max);
    b.command = cmd;
    b.key_code = key;
    b.read_in_progress = rip;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_line_edit(b));
    if (cmd == CMD_READ || key != KEY_NUL) beats_sent++;
  endtask

  // Keys carry a random read_in_progress bit; the block must ignore it.
  task automatic press_key(logic [7:0] key);
    send_beat(CMD_KEY, key, 1'($urandom_range(0, 1)));
  endtask

  // Reads carry a random key code; the block must ignore it.
  task automatic pop_byte(logic rip);
    send_beat(CMD_READ, 8'($urandom_range(0, 255)), rip);
  endtask

  function automatic logic [7:0] printable_key();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // Key drawn for a typed line: mostly printable text, some edit and
  // request keys, and now and then any nonzero code.
  function automatic logic [7:0] line_key();
    case ($urandom_range(0, 19))
      0:       return KEY_CTRL_H;
      1:       return KEY_DEL;
      2:       return KEY_CTRL_U;
      3:       return ($urandom_range(0, 1) != 0) ? KEY_CTRL_P : KEY_CTRL_T;
      4:       return 8'($urandom_range(1, 255));
      default: return printable_key();
    endcase
  endfunction

  function automatic int pick_gap_bound();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return MAX_GAP;
    endcase
  endfunction

  // Result side: stall for a drawn number of cycles, then take one beat and
  // check it field by field against the oldest prediction.
  initial begin : result_checker
    int   hold;
    out_t want;
    out_t got;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = $urandom_range(0, recv_gap_max);
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d char %h count %0d ready %b",
               got.kind, got.char_out, got.erase_count, got.line_ready);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          mismatches++;
        end
        if (got.char_out !== want.char_out) begin
          $error("char_out: expected %h, got %h", want.char_out, got.char_out);
          mismatches++;
        end
        if (got.erase_count !== want.erase_count) begin
          $error("erase_count: expected %0d, got %0d", want.erase_count, got.erase_count);
          mismatches++;
        end
        if (got.line_ready !== want.line_ready) begin
          $error("line_ready: expected %b, got %b", want.line_ready, got.line_ready);
          mismatches++;
        end
      end
    end
  end

  // Editing keys on an empty ring: ignored key, erase with nothing to erase,
  // both requests, extremes of the key code, DEL, kill line with and without
  // characters, carriage return turned into a committing newline, and an
  // erase that must not reach into a committed line.
  task automatic test_edit_keys();
    press_key(KEY_NUL);
    press_key(KEY_CTRL_H);
    press_key(KEY_CTRL_P);
    press_key(KEY_CTRL_T);
    press_key(8'h61);
    press_key(8'hff);
    press_key(8'h01);
    press_key(KEY_DEL);
    press_key(KEY_CTRL_U);
    press_key(KEY_CTRL_U);
    press_key(8'h78);
    press_key(KEY_CR);
    press_key(KEY_CTRL_H);
  endtask

  // Reads: bytes, empty ring, and ctrl-D popped with and without earlier
  // bytes in the same read (kept in the first case, consumed in the second).
  task automatic test_reads_and_eof();
    pop_byte(1'b0);
    pop_byte(1'b1);
    pop_byte(1'b1);
    press_key(8'h79);
    press_key(KEY_CTRL_D);
    pop_byte(1'b0);
    pop_byte(1'b1);
    pop_byte(1'b0);
    pop_byte(1'b0);
    press_key(KEY_CTRL_D);
    pop_byte(1'b1);
    pop_byte(1'b0);
  endtask

  // Fill the ring until it commits on its own, push one key that must be
  // dropped and an erase that must find nothing, then drain. The second
  // round starts mid-ring so the slots wrap.
  task automatic fill_and_check_full();
    while (8'(ed_ptr - rd_ptr) != 8'(RING_DEPTH)) begin
      press_key(($urandom_range(0, 15) == 0) ? KEY_NL : printable_key());
    end
    press_key(printable_key());
    press_key(KEY_CTRL_H);
  endtask

  task automatic test_ring_full();
    send_gap_max = 0;
    recv_gap_max = 0;
    fill_and_check_full();
    repeat (RING_DEPTH / 2) pop_byte(1'($urandom_range(0, 1)));
    send_gap_max = MAX_GAP;
    recv_gap_max = MAX_GAP;
    fill_and_check_full();
    while (rd_ptr != cm_ptr) pop_byte(1'($urandom_range(0, 1)));
    pop_byte(1'b0);
  endtask

  // Receiver holds off for a long stretch while the sender streams beats
  // back to back, so the block fills and stalls its input.
  task automatic test_backpressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    long_hold_cycles = 80;
    repeat (12) press_key(printable_key());
    press_key(KEY_NL);
    repeat (16) pop_byte(1'($urandom_range(0, 1)));
  endtask

  // Random sessions: mostly a typed line with edits, ended by newline,
  // carriage return or ctrl-D and read back; the rest raw noise beats.
  // Run until the whole test has sent about 950 beats.
  task automatic test_random_sessions();
    int n_keys;
    while (beats_sent < 950) begin
      send_gap_max = pick_gap_bound();
      recv_gap_max = pick_gap_bound();
      if ($urandom_range(0, 9) < 7) begin
        n_keys = $urandom_range(0, 20);
        repeat (n_keys) press_key(line_key());
        case ($urandom_range(0, 2))
          0:       press_key(KEY_NL);
          1:       press_key(KEY_CR);
          default: press_key(KEY_CTRL_D);
        endcase
        // First read of a burst mostly starts a fresh read, later ones mostly
        // continue it; both choices occur at every position.
        for (int i = 0; i < $urandom_range(0, n_keys + 4); i++) begin
          if (i == 0) pop_byte(1'($urandom_range(0, 7) == 0));
          else        pop_byte(1'($urandom_range(0, 7) != 0));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_beat(cmd_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    rd_ptr = '0;
    cm_ptr = '0;
    ed_ptr = '0;
    mismatches = 0;
    beats_sent = 0;
    send_gap_max = MAX_GAP;
    recv_gap_max = MAX_GAP;
    long_hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edit_keys();
    test_reads_and_eof();
    test_ring_full();
    test_backpressure();
    test_random_sessions();

    // Drop valid and wait for every predicted result, then keep clocking
    // so that a stray extra result would still be caught.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("console_line_edit_buffer: match");
    end else begin
      $display("console_line_edit_buffer: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/cleb_pkg.sv
sv/console_line_edit_buffer.sv
tb/console_line_edit_buffer_tb.sv
